// ===== hdl/mcst_pkg.sv =====
`timescale 1ns / 1ps

package mcst_pkg;

    typedef logic [6:0] t_note;

    typedef struct packed {
        logic       cmd;
        logic [2:0] track;
        t_note      note;
        t_note      velocity;
        logic [2:0] chord_count;
        t_note      chord_note_0;
        t_note      chord_note_1;
        t_note      chord_note_2;
        t_note      chord_note_3;
        t_note      chord_note_4;
        t_note      chord_note_5;
    } t_in_item;

    typedef struct packed {
        logic [7:0] strum_delay;
        t_note      out_velocity;
    } t_out_item;

    localparam logic [2:0] CFG_ENABLE_MASK     = 3'd0;
    localparam logic [2:0] CFG_STRUM_TIMES     = 3'd1;
    localparam logic [2:0] CFG_DIRECTION_MODES = 3'd2;
    localparam logic [2:0] CFG_RAMP_MODES      = 3'd3;
    localparam logic [2:0] CFG_RAMP_PERCENTS   = 3'd4;

    localparam logic [7:0]  RST_ENABLE_MASK     = 8'd0;
    localparam logic [63:0] RST_STRUM_TIMES     = 64'd2170205185142300190;
    localparam logic [15:0] RST_DIRECTION_MODES = 16'd21845;
    localparam logic [15:0] RST_RAMP_MODES      = 16'd0;
    localparam logic [55:0] RST_RAMP_PERCENTS   = 56'd11347652604398100;

    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_RESET   = 1'b1;

    localparam logic [1:0] DIR_UP     = 2'd0;
    localparam logic [1:0] DIR_DOWN   = 2'd1;
    localparam logic [1:0] DIR_UPDOWN = 2'd2;
    localparam logic [1:0] DIR_RANDOM = 2'd3;

    localparam logic [1:0] RAMP_INC = 2'd1;
    localparam logic [1:0] RAMP_DEC = 2'd2;

    localparam logic [15:0] LFSR_SEED  = 16'hACE1;
    localparam logic [6:0]  PCT_MAX    = 7'd100;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam logic [6:0]  VEL_MIN    = 7'd1;
    localparam logic [6:0]  VEL_MAX    = 7'd127;

    localparam int DIV_W      = 16;
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = DIV_W / DIV_BITS;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [2:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [2:0]       remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_DLY,
        ST_DLY_WAIT,
        ST_STP,
        ST_STP_WAIT,
        ST_VEL,
        ST_DONE
    } t_state;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {b, s[15:1]};
    endfunction

endpackage

// ===== hdl/mcst_in_if.sv =====
`timescale 1ns / 1ps

interface mcst_in_if;
    logic                valid;
    logic                ready;
    mcst_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mcst_out_if.sv =====
`timescale 1ns / 1ps

interface mcst_out_if;
    logic                valid;
    logic                ready;
    mcst_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mcst_lane.sv =====
`timescale 1ns / 1ps

module mcst_lane #(
    parameter int LANE = 0
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  mcst_pkg::t_note    i_note,
    input  mcst_pkg::t_note    i_chord_note,
    input  logic [2:0]         i_count,
    output logic               o_hit
);
    import mcst_pkg::*;

    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit <= (i_chord_note == i_note) && (3'(LANE) < i_count);
        end
    end

    assign o_hit = r_hit;

endmodule

// ===== hdl/mcst_merge.sv =====
`timescale 1ns / 1ps

module mcst_merge #(
    parameter int NOTE_LANES = 6
) (
    input  logic [NOTE_LANES-1:0] i_hit,
    output logic [2:0]            o_raw
);
    import mcst_pkg::*;

    // lowest matching lane wins, no match gives position zero
    always_comb begin
        o_raw = 3'd0;
        for (int i = NOTE_LANES - 1; i >= 0; i--) begin
            if (i_hit[i]) begin
                o_raw = 3'(i);
            end
        end
    end

endmodule

// ===== hdl/mcst_div.sv =====
`timescale 1ns / 1ps

module mcst_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcst_pkg::t_div_req i_req,
    output mcst_pkg::t_div_rsp o_rsp
);
    import mcst_pkg::*;

    localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [2:0]       r_rem;
    logic [2:0]       r_div;
    logic [DIV_W-1:0] n_num;
    logic [2:0]       n_rem;

    always_comb begin
        logic [3:0] t;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            t     = {n_rem, n_num[DIV_W-1]};
            n_num = {n_num[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem    = 3'(t - {1'b0, r_div});
                n_num[0] = 1'b1;
            end else begin
                n_rem = t[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= 3'd0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hdl/midi_chord_strum_timing_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// i_in      in   valid / ready    t_in_item: cmd, track, note, velocity, chord
// o_out     out  valid / ready    t_out_item: strum_delay, out_velocity
// i_cfg_*   in   write enable     register index, 64-bit data
// One transaction at a time. Pass-through and reset items go from ST_CHECK to ST_DONE, which
// loads the output register and returns to ST_IDLE; processed notes first pass ST_DLY, ST_STP
// and ST_VEL with their waits, random mode also ST_MOD_WAIT. The shared 4-bits-per-cycle
// divider serves up to three divisions per note. Synchronous active-low reset restores register
// defaults, flags and LFSR. A finished result waits in the output register while the next item
// is taken; a second one holds in its final state until the output register frees.

module midi_chord_strum_timing_core #(
    parameter int TRACKS     = 8,
    parameter int NOTE_LANES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcst_in_if.sink     i_in,
    mcst_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import mcst_pkg::*;

    localparam logic [3:0] TRACKS_W = 4'(TRACKS);
    localparam logic [2:0] NOTES_W  = 3'(NOTE_LANES);

    logic [7:0]  r_enable_mask;
    logic [63:0] r_strum_times;
    logic [15:0] r_direction_modes;
    logic [15:0] r_ramp_modes;
    logic [55:0] r_ramp_percents;

    t_state            r_state;
    t_state            n_state;
    logic [TRACKS-1:0] r_flags;
    logic [TRACKS-1:0] n_flags;
    logic [15:0]       r_lfsr;
    logic [15:0]       n_lfsr;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic        r_cmd;
    logic [2:0]  r_track;
    t_note       r_vel;
    logic [2:0]  r_size;
    logic [2:0]  r_pos;
    logic [13:0] r_vp;
    t_note       r_max;
    logic [7:0]  r_step;
    logic [7:0]  r_res_delay;
    t_note       r_res_vel;

    logic              w_accept;
    logic              w_out_load;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    t_note             w_chord [6];
    logic [NOTE_LANES-1:0] w_hit;
    logic [2:0]        w_raw;
    logic [2:0]        w_size_m1;
    logic [1:0]        w_dir;
    logic [1:0]        w_ramp;
    logic [7:0]        w_time;
    t_note             w_pct;
    logic              w_pass;
    logic              w_flag_cur;
    logic              w_toggle;
    logic [2:0]        w_pos_fixed;
    logic [26:0]       w_max_prod;
    logic signed [11:0] w_v;
    t_note             w_vel_ramped;

    assign w_chord[0] = i_in.data.chord_note_0;
    assign w_chord[1] = i_in.data.chord_note_1;
    assign w_chord[2] = i_in.data.chord_note_2;
    assign w_chord[3] = i_in.data.chord_note_3;
    assign w_chord[4] = i_in.data.chord_note_4;
    assign w_chord[5] = i_in.data.chord_note_5;

    assign w_accept = i_in.valid && i_in.ready;

    genvar g;
    generate
        for (g = 0; g < NOTE_LANES; g++) begin : g_lane
            mcst_lane #(.LANE(g)) u_lane (
                .i_clk        (i_clk),
                .i_load       (w_accept),
                .i_note       (i_in.data.note),
                .i_chord_note (w_chord[g]),
                .i_count      (i_in.data.chord_count),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    mcst_merge #(.NOTE_LANES(NOTE_LANES)) u_merge (
        .i_hit (w_hit),
        .o_raw (w_raw)
    );

    mcst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_size_m1 = r_size - 3'd1;
    assign w_dir     = r_direction_modes[2*r_track +: 2];
    assign w_ramp    = r_ramp_modes[2*r_track +: 2];
    assign w_time    = r_strum_times[8*r_track +: 8];
    assign w_pct     = (r_ramp_percents[7*r_track +: 7] > PCT_MAX) ?
                       PCT_MAX : r_ramp_percents[7*r_track +: 7];

    assign w_pass = (r_cmd == CMD_RESET) || ({1'b0, r_track} >= TRACKS_W) ||
                    !r_enable_mask[r_track] || (r_size < 3'd2) || (r_size > NOTES_W);

    always_comb begin
        w_flag_cur = 1'b0;
        for (int t = 0; t < TRACKS; t++) begin
            if (r_track == 3'(t)) begin
                w_flag_cur = r_flags[t];
            end
        end
    end

    assign w_toggle = (w_raw == w_size_m1);

    always_comb begin
        case (w_dir)
            DIR_UP:     w_pos_fixed = w_raw;
            DIR_DOWN:   w_pos_fixed = w_size_m1 - w_raw;
            DIR_UPDOWN: w_pos_fixed = w_flag_cur ? (w_size_m1 - w_raw) : w_raw;
            default:    w_pos_fixed = w_raw;
        endcase
    end

    always_comb begin
        n_flags = r_flags;
        if (r_state == ST_CHECK) begin
            for (int t = 0; t < TRACKS; t++) begin
                if (r_track == 3'(t)) begin
                    if (r_cmd == CMD_RESET) begin
                        n_flags[t] = 1'b0;
                    end else if (!w_pass && w_dir == DIR_UPDOWN && w_toggle) begin
                        n_flags[t] = ~r_flags[t];
                    end
                end
            end
        end
    end

    always_comb begin
        n_lfsr = r_lfsr;
        if (r_state == ST_CHECK && !w_pass && w_dir == DIR_RANDOM) begin
            n_lfsr = lfsr_next(r_lfsr);
        end
    end

    assign w_max_prod = 27'(r_vp) * 27'(RECIP_100);

    always_comb begin
        logic signed [11:0] sp;
        sp = $signed(12'(11'(r_step) * 11'(r_pos)));
        if (w_ramp == RAMP_INC) begin
            w_v = $signed({5'd0, r_vel}) - $signed({5'd0, r_max}) + sp;
        end else begin
            w_v = $signed({5'd0, r_vel}) + $signed({5'd0, r_max}) - sp;
        end
        if (w_ramp != RAMP_INC && w_ramp != RAMP_DEC) begin
            w_vel_ramped = r_vel;
        end else if (w_v < $signed(12'd1)) begin
            w_vel_ramped = VEL_MIN;
        end else if (w_v > $signed(12'd127)) begin
            w_vel_ramped = VEL_MAX;
        end else begin
            w_vel_ramped = w_v[6:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_pass) begin
                    n_state = ST_DONE;
                end else if (w_dir == DIR_RANDOM) begin
                    n_state = ST_MOD_WAIT;
                end else begin
                    n_state = ST_DLY;
                end
            end
            ST_MOD_WAIT: begin
                if (w_div_rsp.done) n_state = ST_DLY;
            end
            ST_DLY:      n_state = ST_DLY_WAIT;
            ST_DLY_WAIT: begin
                if (w_div_rsp.done) n_state = ST_STP;
            end
            ST_STP:      n_state = ST_STP_WAIT;
            ST_STP_WAIT: begin
                if (w_div_rsp.done) n_state = ST_VEL;
            end
            ST_VEL:      n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready         = 1'b0;
        w_out_load         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = w_size_m1;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_CHECK: begin
                w_div_req.start    = !w_pass && (w_dir == DIR_RANDOM);
                w_div_req.dividend = lfsr_next(r_lfsr);
                w_div_req.divisor  = r_size;
            end
            ST_DLY: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIV_W'(11'(w_time) * 11'(r_pos));
            end
            ST_STP: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIV_W'({r_max, 1'b0});
            end
            ST_DONE: w_out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_flags           <= '0;
            r_lfsr            <= LFSR_SEED;
            r_out_valid       <= 1'b0;
            r_enable_mask     <= RST_ENABLE_MASK;
            r_strum_times     <= RST_STRUM_TIMES;
            r_direction_modes <= RST_DIRECTION_MODES;
            r_ramp_modes      <= RST_RAMP_MODES;
            r_ramp_percents   <= RST_RAMP_PERCENTS;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_lfsr  <= n_lfsr;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE_MASK:     r_enable_mask     <= i_cfg_data[7:0];
                    CFG_STRUM_TIMES:     r_strum_times     <= i_cfg_data;
                    CFG_DIRECTION_MODES: r_direction_modes <= i_cfg_data[15:0];
                    CFG_RAMP_MODES:      r_ramp_modes      <= i_cfg_data[15:0];
                    CFG_RAMP_PERCENTS:   r_ramp_percents   <= i_cfg_data[55:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_in.data.cmd;
            r_track <= i_in.data.track;
            r_vel   <= i_in.data.velocity;
            r_size  <= i_in.data.chord_count;
        end
        case (r_state)
            ST_CHECK: begin
                r_pos       <= w_pos_fixed;
                r_vp        <= 14'(r_vel) * 14'(w_pct);
                r_res_delay <= 8'd0;
                r_res_vel   <= r_vel;
            end
            ST_MOD_WAIT: begin
                if (w_div_rsp.done) r_pos <= w_div_rsp.remainder;
            end
            ST_DLY: r_max <= w_max_prod[25:19];
            ST_DLY_WAIT: begin
                if (w_div_rsp.done) r_res_delay <= w_div_rsp.quotient[7:0];
            end
            ST_STP_WAIT: begin
                if (w_div_rsp.done) r_step <= w_div_rsp.quotient[7:0];
            end
            ST_VEL: r_res_vel <= w_vel_ramped;
            default: ;
        endcase
        if (w_out_load) begin
            r_out_data.strum_delay  <= r_res_delay;
            r_out_data.out_velocity <= r_res_vel;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ===== verif/strum_checker.sv =====
`timescale 1ns / 1ps

module strum_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  mcst_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  mcst_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    output int                  o_results,
    output int                  o_fail
);
    import mcst_pkg::*;

    logic [7:0]  en_mask;
    logic [63:0] spans;
    logic [15:0] dir_modes;
    logic [15:0] ramp_modes;
    logic [55:0] ramp_pcts;
    logic [7:0]  reverse_flags;
    logic [15:0] lfsr;

    t_out_item expected_strums[$];
    t_out_item oldest;
    int        n_mismatch = 0;
    int        n_backlog = 0;

    assign o_fail = n_mismatch + n_backlog;

    task automatic report(input string msg);
        n_mismatch++;
        $display("[%0t] strum mismatch: %s", $realtime, msg);
    endtask

    function automatic t_out_item predict_strum(input t_in_item it);
        t_out_item  res;
        logic [1:0] dir;
        logic [1:0] ramp;
        logic       fb;
        t_note      chord [6];
        int         sz, raw, pos, span, pct, maxc, step, v;
        res.strum_delay  = '0;
        res.out_velocity = it.velocity;
        if (it.cmd == CMD_RESET) begin
            reverse_flags[it.track] = 1'b0;
            return res;
        end
        if (!en_mask[it.track])
            return res;
        sz = it.chord_count;
        if (sz < 2 || sz > 6)
            return res;
        chord = '{it.chord_note_0, it.chord_note_1, it.chord_note_2,
                  it.chord_note_3, it.chord_note_4, it.chord_note_5};
        // first match wins
        raw = 0;
        for (int i = sz - 1; i >= 0; i--)
            if (chord[i] == it.note)
                raw = i;
        dir = dir_modes[2*it.track +: 2];
        case (dir)
            DIR_UP: pos = raw;
            DIR_DOWN: pos = sz - 1 - raw;
            DIR_UPDOWN: begin
                pos = reverse_flags[it.track] ? sz - 1 - raw : raw;
                if (raw == sz - 1)
                    reverse_flags[it.track] = ~reverse_flags[it.track];
            end
            default: begin
                fb   = ^(lfsr & 16'h002D);
                lfsr = {fb, lfsr[15:1]};
                pos  = int'(lfsr) % sz;
            end
        endcase
        span = spans[8*it.track +: 8];
        res.strum_delay = 8'((span * pos) / (sz - 1));
        ramp = ramp_modes[2*it.track +: 2];
        pct  = ramp_pcts[7*it.track +: 7];
        if (pct > PCT_MAX)
            pct = PCT_MAX;
        if (ramp == RAMP_INC || ramp == RAMP_DEC) begin
            maxc = (int'(it.velocity) * pct) / 100;
            step = (2 * maxc) / (sz - 1);
            if (ramp == RAMP_INC)
                v = int'(it.velocity) - maxc + step * pos;
            else
                v = int'(it.velocity) + maxc - step * pos;
            if (v < VEL_MIN)
                v = VEL_MIN;
            if (v > VEL_MAX)
                v = VEL_MAX;
            res.out_velocity = 7'(v);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            en_mask       = RST_ENABLE_MASK;
            spans         = RST_STRUM_TIMES;
            dir_modes     = RST_DIRECTION_MODES;
            ramp_modes    = RST_RAMP_MODES;
            ramp_pcts     = RST_RAMP_PERCENTS;
            reverse_flags = '0;
            lfsr          = LFSR_SEED;
            expected_strums.delete();
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE_MASK:     en_mask    = i_cfg_data[7:0];
                    CFG_STRUM_TIMES:     spans      = i_cfg_data;
                    CFG_DIRECTION_MODES: dir_modes  = i_cfg_data[15:0];
                    CFG_RAMP_MODES:      ramp_modes = i_cfg_data[15:0];
                    CFG_RAMP_PERCENTS:   ramp_pcts  = i_cfg_data[55:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_strums.push_back(predict_strum(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_strums.size() == 0) begin
                    report($sformatf("result %0d with nothing pending (delay %0d, vel %0d)",
                                     o_results, i_out_data.strum_delay,
                                     i_out_data.out_velocity));
                end else begin
                    oldest = expected_strums.pop_front();
                    if (i_out_data.strum_delay !== oldest.strum_delay)
                        report($sformatf("result %0d strum_delay: got %0d, want %0d",
                                         o_results, i_out_data.strum_delay,
                                         oldest.strum_delay));
                    if (i_out_data.out_velocity !== oldest.out_velocity)
                        report($sformatf("result %0d out_velocity: got %0d, want %0d",
                                         o_results, i_out_data.out_velocity,
                                         oldest.out_velocity));
                end
                o_results <= o_results + 1;
            end
        end
        n_backlog <= expected_strums.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mcst_pkg::*;

    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 180;
    localparam logic [1:0]  RAMP_OFF    = 2'd0;
    localparam logic [1:0]  RAMP_OFF_HI = 2'd3;
    localparam t_note       NOTE_ABSENT = 7'd50;

    typedef struct packed {
        logic [7:0]  en;
        logic [63:0] spans;
        logic [15:0] dirs;
        logic [15:0] ramps;
        logic [55:0] pcts;
    } t_strum_setup;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    int          n_sent = 0;
    int          n_results;
    int          n_fail;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    mcst_in_if  in_ch ();
    mcst_out_if out_ch ();

    midi_chord_strum_timing_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    strum_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_results   (n_results),
        .o_fail      (n_fail)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_note chord_at(input t_in_item it, input int k);
        case (k)
            0: return it.chord_note_0;
            1: return it.chord_note_1;
            2: return it.chord_note_2;
            3: return it.chord_note_3;
            4: return it.chord_note_4;
            default: return it.chord_note_5;
        endcase
    endfunction

    function automatic t_in_item strum_item(input logic cmd, input int track, input int note,
                                            input int vel, input int count);
        t_in_item it;
        it.cmd          = cmd;
        it.track        = 3'(track);
        it.note         = 7'(note);
        it.velocity     = 7'(vel);
        it.chord_count  = 3'(count);
        it.chord_note_0 = 7'd60;
        it.chord_note_1 = 7'd64;
        it.chord_note_2 = 7'd67;
        it.chord_note_3 = 7'd71;
        it.chord_note_4 = 7'd74;
        it.chord_note_5 = 7'd77;
        return it;
    endfunction

    function automatic t_in_item random_chord();
        t_in_item it;
        int       sz, k;
        it.cmd      = ($urandom_range(0, 99) < 6) ? CMD_RESET : CMD_PROCESS;
        it.track    = 3'($urandom_range(0, 7));
        it.velocity = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 85) begin
            sz = $urandom_range(2, 6);
        end else begin
            k  = $urandom_range(0, 2);
            sz = (k == 2) ? 7 : k;
        end
        it.chord_count  = 3'(sz);
        it.chord_note_0 = 7'($urandom);
        it.chord_note_1 = 7'($urandom);
        it.chord_note_2 = 7'($urandom);
        it.chord_note_3 = 7'($urandom);
        it.chord_note_4 = 7'($urandom);
        it.chord_note_5 = 7'($urandom);
        if ($urandom_range(0, 9) == 0)
            it.chord_note_3 = it.chord_note_1;
        if ($urandom_range(0, 99) < 30) begin
            it.note = 7'($urandom);
        end else begin
            if (sz < 2 || sz > 6)
                k = $urandom_range(0, 5);
            else if ($urandom_range(0, 3) == 0)
                k = sz - 1;
            else
                k = $urandom_range(0, sz - 1);
            it.note = chord_at(it, k);
        end
        return it;
    endfunction

    function automatic t_strum_setup phase_setup(input int p);
        t_strum_setup s;
        if (p == 1) begin
            s = '1;
        end else if (p == 2) begin
            s    = '0;
            s.en = 8'hFF;
        end else begin
            s.en    = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
            s.spans = {$urandom, $urandom};
            s.dirs  = 16'($urandom);
            s.ramps = 16'($urandom);
            for (int t = 0; t < 8; t++)
                s.pcts[7*t +: 7] = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                               : 7'($urandom_range(0, 100));
        end
        return s;
    endfunction

    task automatic send_chord(input t_in_item it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        gap = idle_len(tx_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (n_results != n_sent)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic program_setup(input t_strum_setup s);
        write_reg(CFG_ENABLE_MASK, 64'(s.en));
        write_reg(CFG_STRUM_TIMES, s.spans);
        write_reg(CFG_DIRECTION_MODES, 64'(s.dirs));
        write_reg(CFG_RAMP_MODES, 64'(s.ramps));
        write_reg(CFG_RAMP_PERCENTS, 64'(s.pcts));
        cfg_we <= 1'b0;
    endtask

    initial begin
        int       stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                stall = idle_len(rx_calm);
            end
        end
    end

    initial begin
        t_strum_setup setup;
        t_in_item     base, it;
        int           items, k;
        bit           downward;

        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= '0;
        cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults leave every track disabled
        send_chord(strum_item(CMD_PROCESS, 1, 64, 90, 4));
        send_chord(strum_item(CMD_RESET, 7, 0, 127, 0));
        drain_results();

        setup.en    = 8'b1111_1110;
        setup.spans = {8'd200, 8'd37, 8'd0, 8'd90, 8'd30, 8'd100, 8'd255, 8'd16};
        setup.dirs  = {DIR_UPDOWN, DIR_DOWN, DIR_UP, DIR_RANDOM,
                       DIR_UPDOWN, DIR_DOWN, DIR_UP, DIR_UP};
        setup.ramps = {RAMP_INC, RAMP_OFF_HI, RAMP_OFF, RAMP_DEC,
                       RAMP_INC, RAMP_DEC, RAMP_INC, RAMP_OFF};
        setup.pcts  = {7'd127, 7'd50, 7'd0, 7'd100, 7'd101, 7'd100, 7'd25, 7'd0};
        program_setup(setup);

        send_chord(strum_item(CMD_PROCESS, 1, 60, 100, 4));
        send_chord(strum_item(CMD_PROCESS, 1, 71, 100, 4));
        send_chord(strum_item(CMD_PROCESS, 1, NOTE_ABSENT, 100, 4));
        send_chord(strum_item(CMD_PROCESS, 1, 60, 100, 0));
        send_chord(strum_item(CMD_PROCESS, 1, 60, 100, 1));
        send_chord(strum_item(CMD_PROCESS, 1, 60, 100, 7));
        send_chord(strum_item(CMD_PROCESS, 1, 64, 0, 4));
        send_chord(strum_item(CMD_PROCESS, 2, 77, 127, 6));
        send_chord(strum_item(CMD_PROCESS, 2, 60, 127, 6));
        send_chord(strum_item(CMD_PROCESS, 3, 60, 80, 3));
        send_chord(strum_item(CMD_PROCESS, 3, 67, 80, 3));
        send_chord(strum_item(CMD_PROCESS, 3, 60, 80, 3));
        send_chord(strum_item(CMD_PROCESS, 3, 67, 80, 3));
        send_chord(strum_item(CMD_PROCESS, 3, 64, 80, 3));
        send_chord(strum_item(CMD_RESET, 3, 0, 55, 3));
        send_chord(strum_item(CMD_PROCESS, 3, 60, 80, 3));
        send_chord(strum_item(CMD_PROCESS, 4, 60, 127, 5));
        send_chord(strum_item(CMD_PROCESS, 4, 64, 64, 5));
        send_chord(strum_item(CMD_PROCESS, 4, 74, 1, 5));
        send_chord(strum_item(CMD_PROCESS, 5, 64, 0, 3));
        send_chord(strum_item(CMD_PROCESS, 6, 67, 0, 3));
        send_chord(strum_item(CMD_PROCESS, 7, 60, 1, 2));
        send_chord(strum_item(CMD_PROCESS, 7, 64, 127, 2));
        send_chord(strum_item(CMD_PROCESS, 0, 60, 100, 4));
        it = strum_item(CMD_PROCESS, 1, 127, 127, 3);
        it.chord_note_0 = 7'd127;
        it.chord_note_1 = 7'd127;
        send_chord(it);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            program_setup(phase_setup(p));
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 3 == 2);
            items   = 0;
            while (items < PHASE_ITEMS) begin
                base = random_chord();
                if (base.cmd == CMD_PROCESS && base.chord_count >= 2 &&
                    base.chord_count <= 6 && $urandom_range(0, 3) != 0) begin
                    // play the chord note by note, as a strum would
                    downward = 1'($urandom_range(0, 1));
                    for (k = 0; k < base.chord_count && items < PHASE_ITEMS; k++) begin
                        it          = base;
                        it.note     = chord_at(base, downward ? base.chord_count - 1 - k : k);
                        it.velocity = 7'($urandom_range(0, 127));
                        send_chord(it);
                        items++;
                    end
                end else begin
                    send_chord(base);
                    items++;
                end
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
